### hw/rtl/vnt_pkg.sv
// shared types and constants for the value noise turbulence core
// used by vnt_mac, vnt_seq and value_noise_turbulence_core
package vnt_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CW    = 9;   // grid coordinate and size width
  localparam int KW    = 3;   // octave log2 width
  localparam int NW    = 15;  // noise fraction width
  localparam int WTW   = 8;   // per-axis weight width
  localparam int ACCW  = 31;  // accumulator width
  localparam int OUTW  = 24;  // result width
  localparam int PAW   = 4;   // config byte address width

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_START_SIZE  = 2'd2;

  localparam logic [CW-1:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [CW-1:0] GRID_HEIGHT_RST = 9'd256;
  localparam logic [KW-1:0] START_SIZE_RST  = 3'd6;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic          req_type;
    logic [7:0]    pos_x;
    logic [7:0]    pos_y;
    logic [NW-1:0] noise_in;
  } req_t;

  typedef struct packed {
    logic [OUTW-1:0] turbulence;
    logic            was_query;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic mul_wt;
    logic mul_noise;
    logic accum;
  } mac_ctrl_t;

endpackage

### hw/rtl/vnt_mac.sv
// shared multiplier and accumulator with final output scaling
// depends on vnt_pkg
module vnt_mac (
  input  logic                     clk,
  input  vnt_pkg::mac_ctrl_t       ctrl,
  input  logic [vnt_pkg::WTW-1:0]  wx,
  input  logic [vnt_pkg::WTW-1:0]  wy,
  input  logic [vnt_pkg::NW-1:0]   noise,
  input  logic [vnt_pkg::KW-1:0]   k,
  input  logic [vnt_pkg::KW-1:0]   sh,
  output logic [vnt_pkg::OUTW-1:0] result
);

  logic [15:0]                mul_a;
  logic [15:0]                mul_b;
  logic [31:0]                mul_p;
  logic [29:0]                prod_r;
  logic [vnt_pkg::ACCW-1:0]   acc_r;
  logic [vnt_pkg::ACCW-1:0]   term;
  logic [3:0]                 twok;
  logic [vnt_pkg::ACCW+7:0]   acc_ext;

  always_comb begin
    if (ctrl.mul_noise) begin
      mul_a = prod_r[15:0];
      mul_b = {1'b0, noise};
    end else begin
      mul_a = {8'd0, wx};
      mul_b = {8'd0, wy};
    end
  end

  assign mul_p = mul_a * mul_b;
  assign term  = vnt_pkg::ACCW'(prod_r) << sh;

  always_ff @(posedge clk) begin
    if (ctrl.mul_wt || ctrl.mul_noise) begin
      prod_r <= mul_p[29:0];
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.accum) begin
      acc_r <= acc_r + term;
    end
  end

  assign twok    = {k, 1'b0};
  assign acc_ext = (vnt_pkg::ACCW+8)'(acc_r);

  always_comb begin
    if (twok >= 4'd8) begin
      result = vnt_pkg::OUTW'(acc_ext >> (twok - 4'd8));
    end else begin
      result = vnt_pkg::OUTW'(acc_ext << (4'd8 - twok));
    end
  end

endmodule

### hw/rtl/vnt_seq.sv
// octave sequencer: cell index stepping, corner weights and read addressing
// depends on vnt_pkg
module vnt_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [7:0]              px,
  input  logic [7:0]              py,
  input  logic [vnt_pkg::KW-1:0]  k,
  input  logic [vnt_pkg::CW-1:0]  w,
  input  logic [vnt_pkg::CW-1:0]  h,
  input  logic                    take,
  output logic                    busy,
  output logic                    done,
  output logic [vnt_pkg::CW-1:0]  rd_x,
  output logic [vnt_pkg::CW-1:0]  rd_y,
  output vnt_pkg::mac_ctrl_t      ctrl,
  output logic [vnt_pkg::WTW-1:0] wx,
  output logic [vnt_pkg::WTW-1:0] wy,
  output logic [vnt_pkg::KW-1:0]  k_out,
  output logic [vnt_pkg::KW-1:0]  sh
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MN   = 3'd3;
  localparam logic [2:0] ST_AC   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [3:0]               lvl_r, lvl_nxt;
  logic [1:0]               corner_r, corner_nxt;
  logic [vnt_pkg::CW-1:0]   rx_r, rx_nxt, ry_r, ry_nxt;
  logic [7:0]               px_r, py_r;
  logic [vnt_pkg::KW-1:0]   k_r;
  logic [vnt_pkg::CW-1:0]   w_r, h_r;

  logic [3:0]               lvl_dn;
  logic [vnt_pkg::CW:0]     tx, ty;
  logic [vnt_pkg::CW-1:0]   nx, ny;
  logic [7:0]               one_v, ax, ay, bx, by;

  assign lvl_dn = lvl_r - 4'd1;
  assign tx     = {rx_r, px_r[lvl_dn[2:0]]};
  assign ty     = {ry_r, py_r[lvl_dn[2:0]]};
  assign nx     = (rx_r == '0) ? w_r - 9'd1 : rx_r - 9'd1;
  assign ny     = (ry_r == '0) ? h_r - 9'd1 : ry_r - 9'd1;

  assign one_v = 8'd1 << lvl_r[2:0];
  assign ax    = px_r & (one_v - 8'd1);
  assign ay    = py_r & (one_v - 8'd1);
  assign bx    = one_v - ax;
  assign by    = one_v - ay;

  assign rd_x  = corner_r[0] ? nx : rx_r;
  assign rd_y  = corner_r[1] ? ny : ry_r;
  assign wx    = corner_r[0] ? bx : ax;
  assign wy    = corner_r[1] ? by : ay;
  assign k_out = k_r;
  assign sh    = k_r - lvl_r[2:0];
  assign busy  = (state_r != ST_IDLE);
  assign done  = (state_r == ST_FIN);

  always_comb begin
    state_nxt  = state_r;
    lvl_nxt    = lvl_r;
    corner_nxt = corner_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    ctrl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.clr  = 1'b1;
          lvl_nxt   = 4'd8;
          rx_nxt    = '0;
          ry_nxt    = '0;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        lvl_nxt = lvl_dn;
        rx_nxt  = (tx >= {1'b0, w_r}) ? vnt_pkg::CW'(tx - {1'b0, w_r}) : tx[vnt_pkg::CW-1:0];
        ry_nxt  = (ty >= {1'b0, h_r}) ? vnt_pkg::CW'(ty - {1'b0, h_r}) : ty[vnt_pkg::CW-1:0];
        if (lvl_dn <= {1'b0, k_r}) begin
          corner_nxt = 2'd0;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        ctrl.mul_wt = 1'b1;
        state_nxt   = ST_MN;
      end
      ST_MN: begin
        ctrl.mul_noise = 1'b1;
        state_nxt      = ST_AC;
      end
      ST_AC: begin
        ctrl.accum = 1'b1;
        corner_nxt = corner_r + 2'd1;
        if (corner_r != 2'd3) begin
          state_nxt = ST_RD;
        end else if (lvl_r == 4'd0) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_FIN: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r    <= lvl_nxt;
    corner_r <= corner_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    if (state_r == ST_IDLE && start) begin
      px_r <= px;
      py_r <= py;
      k_r  <= k;
      w_r  <= w;
      h_r  <= h;
    end
  end

endmodule

### hw/rtl/value_noise_turbulence_core.sv
// Value noise turbulence core. A write transfer stores one 15-bit noise
// fraction at (pos_x, pos_y) and is acknowledged with a zero result in the
// next cycle. A query transfer sums bilinear smoothed noise over octaves
// from 2^start_size_log2 down to 1 and returns unsigned 8.16 turbulence.
// A query runs through one shared multiplier and accumulator: each grid
// corner passes a weight multiply, a noise multiply and an accumulate step,
// four corners per octave, plus one cell index step per level as the level
// counts down from 8 to 0. The noise store has no reset; entries read
// before being written return undefined values.
// depends on vnt_pkg, vnt_seq, vnt_mac
module value_noise_turbulence_core #(
  parameter int MAX_WIDTH  = vnt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vnt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  vnt_pkg::req_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output vnt_pkg::rsp_t             out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vnt_pkg::PAW-1:0]   paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [vnt_pkg::CW-1:0] grid_width_r, grid_height_r;
  logic [vnt_pkg::KW-1:0] start_size_r;
  logic [vnt_pkg::CW-1:0] w_eff, h_eff;

  logic [vnt_pkg::NW-1:0] mem [DEPTH];
  logic [vnt_pkg::NW-1:0] rdata_r;
  logic [AW-1:0]          waddr, raddr;
  logic                   wr_en;

  logic                   in_xfer, out_free, cfg_wr;
  logic                   out_valid_r;
  vnt_pkg::rsp_t          out_data_r;

  logic                   busy, done, take;
  logic [vnt_pkg::CW-1:0] rd_x, rd_y;
  vnt_pkg::mac_ctrl_t     ctrl;
  logic [vnt_pkg::WTW-1:0] wx, wy;
  logic [vnt_pkg::KW-1:0] k_cur, sh;
  logic [vnt_pkg::OUTW-1:0] result;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= vnt_pkg::GRID_WIDTH_RST;
      grid_height_r <= vnt_pkg::GRID_HEIGHT_RST;
      start_size_r  <= vnt_pkg::START_SIZE_RST;
    end else if (cfg_wr && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        vnt_pkg::REG_GRID_WIDTH:  grid_width_r  <= pwdata[vnt_pkg::CW-1:0];
        vnt_pkg::REG_GRID_HEIGHT: grid_height_r <= pwdata[vnt_pkg::CW-1:0];
        vnt_pkg::REG_START_SIZE:  start_size_r  <= pwdata[vnt_pkg::KW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vnt_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_r);
      vnt_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_r);
      vnt_pkg::REG_START_SIZE:  prdata = 32'(start_size_r);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = 9'd1;
    end else if (11'(grid_width_r) > 11'(MAX_WIDTH)) begin
      w_eff = vnt_pkg::CW'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r == '0) begin
      h_eff = 9'd1;
    end else if (11'(grid_height_r) > 11'(MAX_HEIGHT)) begin
      h_eff = vnt_pkg::CW'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_r;
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !busy && out_free;
  assign in_xfer   = in_valid && in_ready;
  assign take      = done && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_data.req_type == vnt_pkg::REQ_WRITE) begin
      out_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.req_type == vnt_pkg::REQ_WRITE) begin
      out_data_r.turbulence <= '0;
      out_data_r.was_query  <= 1'b0;
    end else if (take) begin
      out_data_r.turbulence <= result;
      out_data_r.was_query  <= 1'b1;
    end
  end

  // noise store
  assign wr_en = in_xfer && in_data.req_type == vnt_pkg::REQ_WRITE
                 && 11'(in_data.pos_x) < 11'(MAX_WIDTH)
                 && 11'(in_data.pos_y) < 11'(MAX_HEIGHT);
  assign waddr = AW'(in_data.pos_y) * AW'(MAX_WIDTH) + AW'(in_data.pos_x);
  assign raddr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= in_data.noise_in;
    end
    rdata_r <= mem[raddr];
  end

  vnt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer && in_data.req_type == vnt_pkg::REQ_QUERY),
    .px    (in_data.pos_x),
    .py    (in_data.pos_y),
    .k     (start_size_r),
    .w     (w_eff),
    .h     (h_eff),
    .take  (take),
    .busy  (busy),
    .done  (done),
    .rd_x  (rd_x),
    .rd_y  (rd_y),
    .ctrl  (ctrl),
    .wx    (wx),
    .wy    (wy),
    .k_out (k_cur),
    .sh    (sh)
  );

  vnt_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .wx     (wx),
    .wy     (wy),
    .noise  (rdata_r),
    .k      (k_cur),
    .sh     (sh),
    .result (result)
  );

endmodule

### verif/value_noise_turbulence_core_tb.sv
// testbench for value_noise_turbulence_core: noise writes and turbulence queries
// checked against an in-bench predictor, with APB setup of grid size and octaves
// depends on vnt_pkg and value_noise_turbulence_core
`timescale 1ns / 100ps

module value_noise_turbulence_core_tb;
  import vnt_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  req_t           in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rsp_t           out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  value_noise_turbulence_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CW-1:0] cfg_grid_w = GRID_WIDTH_RST;
  logic [CW-1:0] cfg_grid_h = GRID_HEIGHT_RST;
  logic [KW-1:0] cfg_start_k = START_SIZE_RST;
  logic [NW-1:0] noise_mem [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
  bit            noise_written [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];

  rsp_t due_results[$];
  rsp_t due_head;
  int   mismatch_count = 0;
  int   items_sent = 0;
  int   send_idle_pct = 7;
  int   recv_idle_pct = 57;
  int   hold_request = 0;
  int   hold_left = 0;

  function automatic int cell_index(input logic [7:0] x, input logic [7:0] y);
    return int'(y) * MAX_WIDTH_DEF + int'(x);
  endfunction

  function automatic longint unsigned used_dim(input logic [CW-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // corners in order: cell, left neighbor, upper neighbor, diagonal neighbor
  function automatic void corner_cells(input logic [7:0] px, input logic [7:0] py,
                                       input int s, output logic [3:0][7:0] cx,
                                       output logic [3:0][7:0] cy);
    longint unsigned w, h, x1, y1;
    w = used_dim(cfg_grid_w, MAX_WIDTH_DEF);
    h = used_dim(cfg_grid_h, MAX_HEIGHT_DEF);
    x1 = (longint'(px) >> s) % w;
    y1 = (longint'(py) >> s) % h;
    cx[0] = 8'(x1);
    cx[1] = 8'((x1 + w - 1) % w);
    cx[2] = cx[0];
    cx[3] = cx[1];
    cy[0] = 8'(y1);
    cy[1] = cy[0];
    cy[2] = 8'((y1 + h - 1) % h);
    cy[3] = cy[2];
  endfunction

  function automatic logic [OUTW-1:0] turbulence_at(input logic [7:0] px,
                                                    input logic [7:0] py);
    logic [3:0][7:0] cx, cy;
    longint unsigned k, one, ax, ay, wx, wy, octave_sum, acc, res;
    k = cfg_start_k;
    acc = 0;
    for (int s = int'(k); s >= 0; s--) begin
      one = 64'd1 << s;
      ax = longint'(px) & (one - 1);
      ay = longint'(py) & (one - 1);
      corner_cells(px, py, s, cx, cy);
      octave_sum = 0;
      for (int c = 0; c < 4; c++) begin
        wx = (c % 2 == 1) ? one - ax : ax;
        wy = (c >= 2) ? one - ay : ay;
        octave_sum += wx * wy * longint'(noise_mem[cell_index(cx[c], cy[c])]);
      end
      acc += octave_sum << (k - s);
    end
    if (2 * k >= 8) res = acc >> (2 * k - 8);
    else res = acc << (8 - 2 * k);
    return res[OUTW-1:0];
  endfunction

  function automatic logic [NW-1:0] random_noise();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return NW'($urandom);
    endcase
  endfunction

  task automatic send_item(input req_t item);
    int idx;
    idx = cell_index(item.pos_x, item.pos_y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    if (item.req_type == REQ_WRITE) begin
      noise_mem[idx] = item.noise_in;
      noise_written[idx] = 1'b1;
      due_results.push_back(rsp_t'{turbulence: '0, was_query: 1'b0});
    end else begin
      due_results.push_back(rsp_t'{turbulence: turbulence_at(item.pos_x, item.pos_y),
                                   was_query: 1'b1});
    end
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic write_noise(input logic [7:0] x, input logic [7:0] y,
                             input logic [NW-1:0] v);
    send_item(req_t'{req_type: REQ_WRITE, pos_x: x, pos_y: y, noise_in: v});
  endtask

  // every corner a query touches must hold a written value
  task automatic query_at(input logic [7:0] px, input logic [7:0] py);
    logic [3:0][7:0] cx, cy;
    for (int s = int'(cfg_start_k); s >= 0; s--) begin
      corner_cells(px, py, s, cx, cy);
      for (int c = 0; c < 4; c++)
        if (!noise_written[cell_index(cx[c], cy[c])])
          write_noise(cx[c], cy[c], random_noise());
    end
    send_item(req_t'{req_type: REQ_QUERY, pos_x: px, pos_y: py, noise_in: NW'($urandom)});
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRID_WIDTH: cfg_grid_w = value[CW-1:0];
      REG_GRID_HEIGHT: cfg_grid_h = value[CW-1:0];
      REG_START_SIZE: cfg_start_k = value[KW-1:0];
      default: ;
    endcase
  endtask

  task automatic random_item();
    longint unsigned w, h;
    logic [7:0] x, y;
    w = used_dim(cfg_grid_w, MAX_WIDTH_DEF);
    h = used_dim(cfg_grid_h, MAX_HEIGHT_DEF);
    if ($urandom_range(99) < 55) begin
      query_at(8'($urandom), 8'($urandom));
    end else begin
      if ($urandom_range(9) < 6) begin
        x = 8'($urandom_range(int'(w) - 1));
        y = 8'($urandom_range(int'(h) - 1));
      end else begin
        x = 8'($urandom);
        y = 8'($urandom);
      end
      write_noise(x, y, random_noise());
    end
  endtask

  function automatic logic [CW-1:0] pick_dim();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 9'd0;
          1: return 9'd1;
          2: return 9'd256;
          default: return CW'($urandom_range(257, 511));
        endcase
      end
      1: return CW'($urandom_range(17, 256));
      default: return CW'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic test_reset_defaults();
    write_noise(8'd0, 8'd0, 15'h7FFF);
    write_noise(8'd255, 8'd255, 15'h0000);
    write_noise(8'd255, 8'd0, 15'h5555);
    write_noise(8'd0, 8'd255, 15'h2AAA);
    query_at(8'd0, 8'd0);
    query_at(8'd1, 8'd1);
  endtask

  task automatic test_directed_extremes();
    write_reg(REG_GRID_WIDTH, 32'd1);
    write_reg(REG_GRID_HEIGHT, 32'd1);
    write_reg(REG_START_SIZE, 32'd7);
    write_noise(8'd0, 8'd0, 15'h7FFF);
    query_at(8'd255, 8'd255);
    query_at(8'd0, 8'd0);
    query_at(8'd170, 8'd85);
    write_noise(8'd0, 8'd0, 15'h0000);
    query_at(8'd255, 8'd0);
  endtask

  task automatic test_grid_corner_cases();
    // zero sizes act as a single cell
    write_reg(REG_GRID_WIDTH, 32'd0);
    write_reg(REG_GRID_HEIGHT, 32'd0);
    write_reg(REG_START_SIZE, 32'd3);
    query_at(8'd255, 8'd0);
    // oversized grid saturates to the store size
    write_reg(REG_GRID_WIDTH, 32'd511);
    write_reg(REG_GRID_HEIGHT, 32'd300);
    write_reg(REG_START_SIZE, 32'd0);
    query_at(8'd255, 8'd255);
    query_at(8'd0, 8'd0);
    // pixels past a small grid wrap, writes past it are still stored
    write_reg(REG_GRID_WIDTH, 32'd4);
    write_reg(REG_GRID_HEIGHT, 32'd4);
    write_reg(REG_START_SIZE, 32'd2);
    query_at(8'd255, 8'd37);
    write_noise(8'd200, 8'd100, 15'h7FFF);
    write_reg(REG_UNUSED, 32'h1FF);
    write_reg(REG_GRID_WIDTH, 32'd256);
    write_reg(REG_GRID_HEIGHT, 32'd256);
    write_reg(REG_START_SIZE, 32'd0);
    query_at(8'd201, 8'd101);
  endtask

  task automatic test_output_hold();
    write_reg(REG_GRID_WIDTH, 32'd8);
    write_reg(REG_GRID_HEIGHT, 32'd8);
    write_reg(REG_START_SIZE, 32'd3);
    send_idle_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 24; i++) begin
      if (i % 2 == 0) write_noise(8'($urandom_range(7)), 8'($urandom_range(7)), random_noise());
      else query_at(8'($urandom), 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int phase_end;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 7; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 7; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 6; ph++) begin
        write_reg(REG_GRID_WIDTH, 32'(pick_dim()));
        write_reg(REG_GRID_HEIGHT, 32'(pick_dim()));
        write_reg(REG_START_SIZE, 32'($urandom_range(7)));
        phase_end = items_sent + 105;
        while (items_sent < phase_end) random_item();
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: turbulence %h was_query %b",
                   out_data.turbulence, out_data.was_query);
      end else begin
        due_head = due_results.pop_front();
        if (out_data.turbulence !== due_head.turbulence ||
            out_data.was_query !== due_head.was_query) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("turbulence exp %h got %h, was_query exp %b got %b",
                     due_head.turbulence, out_data.turbulence,
                     due_head.was_query, out_data.was_query);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_grid_corner_cases();
    test_output_hold();
    test_random_traffic();
    wait_idle();
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hw/rtl/vnt_pkg.sv
hw/rtl/vnt_mac.sv
hw/rtl/vnt_seq.sv
hw/rtl/value_noise_turbulence_core.sv
verif/value_noise_turbulence_core_tb.sv
